[sv/ttacc_pkg.sv]
// shared types, constants and helpers of the triangle tangent accumulator
package ttacc_pkg;

  localparam int unsigned DATA_W  = 32;
  localparam int unsigned TALLY_W = 16;
  localparam int unsigned IDX_W   = 10;
  localparam int unsigned WIDE_W  = 64;
  localparam int unsigned MUL_W   = DATA_W + 1;
  localparam int unsigned PROD_W  = 2 * MUL_W;
  // reciprocal numerator is 1.0 in q16.16 over a q32.32 determinant, i.e. 2^48
  localparam int unsigned RECIP_SHIFT = 48;
  localparam int unsigned QUOT_W      = RECIP_SHIFT + 1;

  localparam logic [1:0] MODE_LOAD = 2'd0;
  localparam logic [1:0] MODE_TRI  = 2'd1;
  localparam logic [1:0] MODE_READ = 2'd2;

  localparam logic [TALLY_W-1:0] TALLY_MAX = '1;

  typedef enum logic [4:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOAD,
    ST_READ,
    ST_READ_CAP,
    ST_RD_A,
    ST_RD_B,
    ST_RD_C,
    ST_CAP_C,
    ST_DELTA,
    ST_MUL,
    ST_CHECK,
    ST_DIV,
    ST_RECIP,
    ST_SCALE,
    ST_ACC_RD,
    ST_ACC_WR,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic              sat;
    logic [DATA_W-1:0] val;
  } clip_t;

  typedef struct packed {
    logic [2:0][DATA_W-1:0] tan;
    logic [TALLY_W-1:0]     tally;
  } acc_t;

  // 33-bit signed value clipped to 32 bits
  function automatic clip_t clip33(input logic [DATA_W:0] v);
    clip_t c;
    c.sat = (v[DATA_W] != v[DATA_W-1]);
    if (c.sat) begin
      c.val = v[DATA_W] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
    end else begin
      c.val = v[DATA_W-1:0];
    end
    return c;
  endfunction

  // magnitude with a sign applied, clipped to the signed 32-bit range
  function automatic clip_t sign_clip(input logic [WIDE_W-1:0] m, input logic neg);
    clip_t c;
    if (neg) begin
      c.sat = (m > {{(WIDE_W-DATA_W){1'b0}}, 1'b1, {(DATA_W-1){1'b0}}});
      c.val = c.sat ? {1'b1, {(DATA_W-1){1'b0}}} : (~m[DATA_W-1:0] + 1'b1);
    end else begin
      c.sat = (m > {{(WIDE_W-DATA_W+1){1'b0}}, {(DATA_W-1){1'b1}}});
      c.val = c.sat ? {1'b0, {(DATA_W-1){1'b1}}} : m[DATA_W-1:0];
    end
    return c;
  endfunction

endpackage

[sv/ttacc_mul.sv]
// shared signed multiplier with a registered product
module ttacc_mul (
  input  logic                                 clk,
  input  logic signed [ttacc_pkg::MUL_W-1:0]   op_a,
  input  logic signed [ttacc_pkg::MUL_W-1:0]   op_b,
  output logic signed [ttacc_pkg::PROD_W-1:0]  prod
);

  always_ff @(posedge clk) begin
    prod <= op_a * op_b;
  end

endmodule

[sv/ttacc_div.sv]
// restoring divider, one quotient bit a cycle, of 2^48 by a 64-bit magnitude
module ttacc_div (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  input  logic [ttacc_pkg::WIDE_W-1:0]       divisor,
  output logic                               done,
  output logic [ttacc_pkg::QUOT_W-1:0]       quot
);

  localparam int unsigned CNT_W = $clog2(ttacc_pkg::QUOT_W);

  logic                          busy;
  logic [CNT_W-1:0]              bit_cnt;
  logic [ttacc_pkg::WIDE_W-1:0]  rem;
  logic [ttacc_pkg::WIDE_W-1:0]  dvs;
  logic [ttacc_pkg::WIDE_W:0]    shifted;
  logic [ttacc_pkg::WIDE_W:0]    diff;
  logic                          ge;

  always_comb begin
    shifted = {rem, (bit_cnt == CNT_W'(ttacc_pkg::QUOT_W - 1))};
    diff    = shifted - {1'b0, dvs};
    ge      = (shifted >= {1'b0, dvs});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && bit_cnt == '0) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem     <= '0;
      quot    <= '0;
      dvs     <= divisor;
      bit_cnt <= CNT_W'(ttacc_pkg::QUOT_W - 1);
    end else if (busy) begin
      rem     <= ge ? diff[ttacc_pkg::WIDE_W-1:0] : shifted[ttacc_pkg::WIDE_W-1:0];
      quot    <= {quot[ttacc_pkg::QUOT_W-2:0], ge};
      bit_cnt <= bit_cnt - 1'b1;
    end
  end

endmodule

[sv/triangle_tangent_accumulator.sv]
// triangle tangent accumulator: vertex store, tangent sums and mode sequencer
// work: a triangle runs through the 49-step reciprocal divider and makes 14 passes
//   through the one shared multiplier
// throughput: one word at a time, the next word is taken once the result is out
// reset: synchronous; afterwards a clearing pass over all VERTEX_DEPTH entries zeroes
//   the tangent sums and tallies, with in_stall held high until it ends
module triangle_tangent_accumulator #(
  parameter int unsigned VERTEX_DEPTH = 1024
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [1:0]          mode,
  input  logic [9:0]          vertex_index,
  input  logic signed [31:0]  pos_x,
  input  logic signed [31:0]  pos_y,
  input  logic signed [31:0]  pos_z,
  input  logic signed [31:0]  tex_u,
  input  logic signed [31:0]  tex_v,
  input  logic [9:0]          corner_a,
  input  logic [9:0]          corner_b,
  input  logic [9:0]          corner_c,
  output logic                out_valid,
  input  logic                out_stall,
  output logic signed [31:0]  tan_x,
  output logic signed [31:0]  tan_y,
  output logic signed [31:0]  tan_z,
  output logic [15:0]         tri_count,
  output logic                degenerate,
  output logic                saturated
);

  localparam int unsigned DW = ttacc_pkg::DATA_W;
  localparam int unsigned WW = ttacc_pkg::WIDE_W;
  localparam int unsigned AW = $clog2(VERTEX_DEPTH);
  localparam int unsigned XW = 17; // wide enough to hold the depth itself

  ttacc_pkg::state_t state, state_next;

  // captured input word
  logic [1:0]            r_mode;
  logic [9:0]            r_vi, r_ca, r_cb, r_cc;
  logic [4:0][DW-1:0]    r_vert;

  // vertex store (x, y, z, u, v) and tangent store, single port each
  logic [4:0][DW-1:0]    vmem [VERTEX_DEPTH];
  logic [4:0][DW-1:0]    vmem_rdata;
  logic                  vmem_we;
  logic [AW-1:0]         vmem_addr;
  ttacc_pkg::acc_t       amem [VERTEX_DEPTH];
  ttacc_pkg::acc_t       amem_rdata;
  ttacc_pkg::acc_t       amem_wdata;
  logic                  amem_we;
  logic [AW-1:0]         amem_addr;

  // sequencing counters
  logic [AW-1:0]         clr_cnt;
  logic                  dsel;
  logic [2:0]            dj;
  logic [3:0]            pc;
  logic [1:0]            cidx;

  // working values of a triangle
  logic [4:0][DW-1:0]    va, vb, vc;
  logic [4:0][DW-1:0]    d1, d2;     // b - a and c - a: x, y, z, u, v
  logic [3:0][WW-1:0]    sums;       // determinant then numerators x, y, z
  logic [WW-1:0]         hold;
  logic [DW-1:0]         r_mag;
  logic                  r_neg;
  logic [2:0][DW-1:0]    tang;
  logic                  sat;

  // result being built
  logic [2:0][DW-1:0]    res_tan;
  logic [15:0]           res_tally;
  logic                  res_deg;

  // shared units
  logic signed [ttacc_pkg::MUL_W-1:0]  op_a, op_b;
  logic signed [ttacc_pkg::PROD_W-1:0] prod;
  logic                                div_start, div_done;
  logic [ttacc_pkg::QUOT_W-1:0]        quot;

  logic                  accept;
  logic                  vi_ok, tri_ok;
  logic [AW-1:0]         vi_addr, corner_addr;
  logic [9:0]            corner_sel;
  logic                  out_free;

  // combinational datapath helpers
  logic [DW-1:0]         dlt_min, dlt_sub;
  ttacc_pkg::clip_t      dlt_clip;
  logic [2:0]            mj;
  logic [1:0]            mpair, max;
  logic [WW-1:0]         num_mag;
  logic [2:0]            ck;
  logic [1:0]            cax;
  logic [WW-1:0]         scale_m;
  ttacc_pkg::clip_t      scale_clip;
  ttacc_pkg::clip_t      recip_clip;
  ttacc_pkg::clip_t [2:0] add_clip;

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state != ttacc_pkg::ST_IDLE);
  assign out_free = !out_valid || !out_stall;

  function automatic logic in_range(input logic [9:0] idx);
    return XW'(idx) < XW'(VERTEX_DEPTH);
  endfunction

  function automatic logic [AW-1:0] to_addr(input logic [9:0] idx);
    logic [XW-1:0] w;
    w = XW'(idx);
    return w[AW-1:0];
  endfunction

  assign vi_ok   = in_range(r_vi);
  assign tri_ok  = in_range(r_ca) && in_range(r_cb) && in_range(r_cc);
  assign vi_addr = to_addr(r_vi);

  always_comb begin
    unique case (cidx)
      2'd0:    corner_sel = r_ca;
      2'd1:    corner_sel = r_cb;
      default: corner_sel = r_cc;
    endcase
  end
  assign corner_addr = to_addr(corner_sel);

  ttacc_mul u_mul (
    .clk  (clk),
    .op_a (op_a),
    .op_b (op_b),
    .prod (prod)
  );

  ttacc_div u_div (
    .clk     (clk),
    .rst     (rst),
    .start   (div_start),
    .divisor (sums[0][WW-1] ? (~sums[0] + 1'b1) : sums[0]),
    .done    (div_done),
    .quot    (quot)
  );

  assign div_start = (state == ttacc_pkg::ST_CHECK) && (sums[0] != '0);

  // one shared subtractor walks the ten deltas
  always_comb begin
    dlt_min  = dsel ? vc[dj] : vb[dj];
    dlt_sub  = va[dj];
    dlt_clip = ttacc_pkg::clip33({dlt_min[DW-1], dlt_min} - {dlt_sub[DW-1], dlt_sub});
  end

  // multiplier operand select: determinant and numerator products, then scaling
  always_comb begin
    mj      = pc[2:0];
    mpair   = mj[2:1];
    max     = mpair - 2'd1;
    num_mag = sums[mj[2:1] + 2'd1][WW-1] ? (~sums[mj[2:1] + 2'd1] + 1'b1)
                                         : sums[mj[2:1] + 2'd1];
    op_a    = '0;
    op_b    = '0;
    if (state == ttacc_pkg::ST_MUL) begin
      if (mpair == 2'd0) begin
        op_a = mj[0] ? $signed({d1[4][DW-1], d1[4]}) : $signed({d1[3][DW-1], d1[3]});
        op_b = mj[0] ? $signed({d2[3][DW-1], d2[3]}) : $signed({d2[4][DW-1], d2[4]});
      end else begin
        op_a = mj[0] ? $signed({d2[max][DW-1], d2[max]}) : $signed({d1[max][DW-1], d1[max]});
        op_b = mj[0] ? $signed({d1[4][DW-1], d1[4]}) : $signed({d2[4][DW-1], d2[4]});
      end
    end else if (state == ttacc_pkg::ST_SCALE) begin
      op_a = $signed({1'b0, mj[0] ? num_mag[WW-1:DW] : num_mag[DW-1:0]});
      op_b = $signed({1'b0, r_mag});
    end
  end

  // scaling: hi + (lo >> 32), sign of numerator against sign of reciprocal
  always_comb begin
    ck         = pc[2:0] - 3'd1;
    cax        = ck[2:1];
    scale_m    = prod[WW-1:0] + {{DW{1'b0}}, hold[WW-1:DW]};
    scale_clip = ttacc_pkg::sign_clip(scale_m, sums[cax + 2'd1][WW-1] ^ r_neg);
    recip_clip = ttacc_pkg::sign_clip(WW'(quot), sums[0][WW-1]);
  end

  // saturating sums into the tangent word read back
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      add_clip[k] = ttacc_pkg::clip33({amem_rdata.tan[k][DW-1], amem_rdata.tan[k]}
                                      + {tang[k][DW-1], tang[k]});
    end
    amem_wdata = '0;
    for (int k = 0; k < 3; k++) begin
      amem_wdata.tan[k] = add_clip[k].val;
    end
    amem_wdata.tally = (amem_rdata.tally == ttacc_pkg::TALLY_MAX) ? amem_rdata.tally
                                                                 : amem_rdata.tally + 1'b1;
  end

  // sequencer: next state and memory controls
  always_comb begin
    state_next = state;
    vmem_we    = 1'b0;
    vmem_addr  = vi_addr;
    amem_we    = 1'b0;
    amem_addr  = vi_addr;
    unique case (state)
      ttacc_pkg::ST_CLEAR: begin
        amem_we   = 1'b1;
        amem_addr = clr_cnt;
        if (clr_cnt == AW'(VERTEX_DEPTH - 1)) begin
          state_next = ttacc_pkg::ST_IDLE;
        end
      end
      ttacc_pkg::ST_IDLE: begin
        if (accept) begin
          priority if (mode == ttacc_pkg::MODE_LOAD) begin
            state_next = ttacc_pkg::ST_LOAD;
          end else if (mode == ttacc_pkg::MODE_READ) begin
            state_next = ttacc_pkg::ST_READ;
          end else if (mode == ttacc_pkg::MODE_TRI) begin
            state_next = ttacc_pkg::ST_RD_A;
          end else begin
            state_next = ttacc_pkg::ST_DONE;
          end
        end
      end
      ttacc_pkg::ST_LOAD: begin
        vmem_we    = vi_ok;
        amem_we    = vi_ok;
        state_next = ttacc_pkg::ST_DONE;
      end
      ttacc_pkg::ST_READ:     state_next = ttacc_pkg::ST_READ_CAP;
      ttacc_pkg::ST_READ_CAP: state_next = ttacc_pkg::ST_DONE;
      ttacc_pkg::ST_RD_A: begin
        vmem_addr  = to_addr(r_ca);
        state_next = tri_ok ? ttacc_pkg::ST_RD_B : ttacc_pkg::ST_DONE;
      end
      ttacc_pkg::ST_RD_B: begin
        vmem_addr  = to_addr(r_cb);
        state_next = ttacc_pkg::ST_RD_C;
      end
      ttacc_pkg::ST_RD_C: begin
        vmem_addr  = to_addr(r_cc);
        state_next = ttacc_pkg::ST_CAP_C;
      end
      ttacc_pkg::ST_CAP_C: state_next = ttacc_pkg::ST_DELTA;
      ttacc_pkg::ST_DELTA: begin
        if (dsel && dj == 3'd4) begin
          state_next = ttacc_pkg::ST_MUL;
        end
      end
      ttacc_pkg::ST_MUL: begin
        if (pc == 4'd8) begin
          state_next = ttacc_pkg::ST_CHECK;
        end
      end
      ttacc_pkg::ST_CHECK: begin
        state_next = (sums[0] == '0) ? ttacc_pkg::ST_DONE : ttacc_pkg::ST_DIV;
      end
      ttacc_pkg::ST_DIV: begin
        if (div_done) begin
          state_next = ttacc_pkg::ST_RECIP;
        end
      end
      ttacc_pkg::ST_RECIP: state_next = ttacc_pkg::ST_SCALE;
      ttacc_pkg::ST_SCALE: begin
        if (pc == 4'd6) begin
          state_next = ttacc_pkg::ST_ACC_RD;
        end
      end
      ttacc_pkg::ST_ACC_RD: begin
        amem_addr  = corner_addr;
        state_next = ttacc_pkg::ST_ACC_WR;
      end
      ttacc_pkg::ST_ACC_WR: begin
        amem_addr  = corner_addr;
        amem_we    = 1'b1;
        state_next = (cidx == 2'd2) ? ttacc_pkg::ST_DONE : ttacc_pkg::ST_ACC_RD;
      end
      ttacc_pkg::ST_DONE: begin
        if (out_free) begin
          state_next = ttacc_pkg::ST_IDLE;
        end
      end
      default: state_next = ttacc_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ttacc_pkg::ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // memories
  always_ff @(posedge clk) begin
    if (vmem_we) begin
      vmem[vmem_addr] <= r_vert;
    end
    vmem_rdata <= vmem[vmem_addr];
  end

  always_ff @(posedge clk) begin
    if (amem_we) begin
      amem[amem_addr] <= (state == ttacc_pkg::ST_ACC_WR) ? amem_wdata : '0;
    end
    amem_rdata <= amem[amem_addr];
  end

  // control counters and output handshake
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt   <= '0;
      dsel      <= 1'b0;
      dj        <= '0;
      pc        <= '0;
      cidx      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (state == ttacc_pkg::ST_CLEAR) begin
        clr_cnt <= clr_cnt + 1'b1;
      end
      if (state == ttacc_pkg::ST_DELTA) begin
        if (dj == 3'd4) begin
          dj   <= '0;
          dsel <= ~dsel;
        end else begin
          dj <= dj + 1'b1;
        end
      end
      if (state == ttacc_pkg::ST_MUL || state == ttacc_pkg::ST_SCALE) begin
        pc <= (state_next == state) ? pc + 1'b1 : '0;
      end
      if (state == ttacc_pkg::ST_ACC_WR) begin
        cidx <= (cidx == 2'd2) ? 2'd0 : cidx + 1'b1;
      end
      if (state == ttacc_pkg::ST_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    unique case (state)
      ttacc_pkg::ST_IDLE: begin
        if (accept) begin
          r_mode    <= mode;
          r_vi      <= vertex_index;
          r_ca      <= corner_a;
          r_cb      <= corner_b;
          r_cc      <= corner_c;
          r_vert    <= {tex_v, tex_u, pos_z, pos_y, pos_x};
          res_tan   <= '0;
          res_tally <= '0;
          res_deg   <= 1'b0;
          sat       <= 1'b0;
        end
      end
      ttacc_pkg::ST_READ_CAP: begin
        if (vi_ok) begin
          res_tan   <= amem_rdata.tan;
          res_tally <= amem_rdata.tally;
        end
      end
      ttacc_pkg::ST_RD_B:  va <= vmem_rdata;
      ttacc_pkg::ST_RD_C:  vb <= vmem_rdata;
      ttacc_pkg::ST_CAP_C: vc <= vmem_rdata;
      ttacc_pkg::ST_DELTA: begin
        if (dsel) begin
          d2[dj] <= dlt_clip.val;
        end else begin
          d1[dj] <= dlt_clip.val;
        end
        sat <= sat | dlt_clip.sat;
      end
      ttacc_pkg::ST_MUL: begin
        // product of step pc-1 is on the multiplier output now
        if (pc != 4'd0) begin
          if (!ck[0]) begin
            hold <= prod[WW-1:0];
          end else begin
            sums[ck[2:1]] <= hold - prod[WW-1:0];
          end
        end
      end
      ttacc_pkg::ST_CHECK: begin
        res_deg <= (sums[0] == '0);
      end
      ttacc_pkg::ST_RECIP: begin
        sat   <= sat | recip_clip.sat;
        r_neg <= recip_clip.val[DW-1];
        r_mag <= recip_clip.val[DW-1] ? (~recip_clip.val + 1'b1) : recip_clip.val;
      end
      ttacc_pkg::ST_SCALE: begin
        if (pc != 4'd0) begin
          if (!ck[0]) begin
            hold <= prod[WW-1:0];
          end else begin
            tang[cax] <= scale_clip.val;
            sat       <= sat | scale_clip.sat;
          end
        end
      end
      ttacc_pkg::ST_ACC_WR: begin
        sat <= sat | add_clip[0].sat | add_clip[1].sat | add_clip[2].sat;
      end
      ttacc_pkg::ST_DONE: begin
        if (out_free) begin
          tan_x      <= res_tan[0];
          tan_y      <= res_tan[1];
          tan_z      <= res_tan[2];
          tri_count  <= res_tally;
          degenerate <= res_deg;
          saturated  <= sat & ~res_deg & (r_mode == ttacc_pkg::MODE_TRI);
        end
      end
      default: begin
      end
    endcase
  end

endmodule

[sv/ttacc_checker.sv]
// port-level checks of the triangle tangent accumulator, bound to the top level
module ttacc_checker (
  input logic         clk,
  input logic         rst,
  input logic         in_valid,
  input logic         in_stall,
  input logic         out_valid,
  input logic         out_stall,
  input logic [31:0]  tan_x,
  input logic [15:0]  tri_count,
  input logic         degenerate,
  input logic         saturated
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("result word dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable(tan_x) && $stable(tri_count))
    else $error("stalled result word changed");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("second word taken while one is in work");

  a_degenerate_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && degenerate |-> !saturated && tan_x == 32'd0 && tri_count == 16'd0)
    else $error("degenerate triangle result carries data");

  a_reset_quiet: assert property (@(posedge clk)
    rst |=> in_stall && !out_valid)
    else $error("block not quiet after reset");

endmodule

bind triangle_tangent_accumulator ttacc_checker u_ttacc_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_valid),
  .in_stall   (in_stall),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .tan_x      (tan_x),
  .tri_count  (tri_count),
  .degenerate (degenerate),
  .saturated  (saturated)
);
